[design/front_middle_back_queue_macros.svh]
// ----------------------------------------------------------------------------
// Front/middle/back queue assertion macros
// Concurrent assertion wrappers used by the queue controller; they expand to
// nothing when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef FRONT_MIDDLE_BACK_QUEUE_MACROS_SVH
`define FRONT_MIDDLE_BACK_QUEUE_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check an expression at every clock edge outside reset.
`define FMBQ_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error(msg);
// Check an implication at every clock edge outside reset.
`define FMBQ_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
		else $error(msg);
`else
`define FMBQ_ASSERT(lbl, clk, rst_n, prop, msg)
`define FMBQ_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

[design/fmbq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Front/middle/back queue package
// Sizes, request opcodes and transaction payload types of the queue.
// ----------------------------------------------------------------------------
package fmbq_pkg;

	localparam int CAPACITY       = 256;
	localparam int VALUE_BITS     = 31;
	localparam int OPCODE_BITS    = 3;
	localparam int COUNT_BITS     = 9;
	// each ring half holds up to ceil(CAPACITY/2) entries, power-of-two depth
	localparam int RING_ADDR_BITS = $clog2((CAPACITY + 1) / 2 + 1);

	localparam logic [OPCODE_BITS-1:0] OP_PUSH_FRONT  = 3'd0;
	localparam logic [OPCODE_BITS-1:0] OP_PUSH_MIDDLE = 3'd1;
	localparam logic [OPCODE_BITS-1:0] OP_PUSH_BACK   = 3'd2;
	localparam logic [OPCODE_BITS-1:0] OP_POP_FRONT   = 3'd3;
	localparam logic [OPCODE_BITS-1:0] OP_POP_MIDDLE  = 3'd4;
	localparam logic [OPCODE_BITS-1:0] OP_POP_BACK    = 3'd5;

	typedef struct packed {
		logic [OPCODE_BITS-1:0] opcode;
		logic [VALUE_BITS-1:0]  push_value;
	} req_t;

	typedef struct packed {
		logic [VALUE_BITS-1:0] popped_value;
		logic                  was_empty;
		logic                  overflow;
		logic [COUNT_BITS-1:0] entry_count;
	} rsp_t;

endpackage

[design/front_middle_back_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Front/middle/back queue
// Bounded deque with middle access, kept as two balanced ring halves.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid/req_stall/req) carries one request per transaction:
//   push or pop at the front, middle or back. rsp channel
//   (rsp_valid/rsp_stall/rsp) returns exactly one response per request:
//   popped value, empty flag for a pop on an empty queue, overflow flag for
//   a dropped push, and the entry count after the request.
//   A response is valid in ST_DONE, which follows ST_RMW after its request
//   is accepted. No request is taken while one is in ST_RMW; the read of
//   the ring memories in the accept cycle and the write back of the
//   rebalancing move in the next cycle keep requests from overlapping.
//   A new request is taken in the same cycle the previous response leaves.
//   Reset clears heads and counts at once; ring contents stay undefined and
//   are never read before written, so there is no clearing pass.
//   While rsp_stall is high the response holds and req_stall stays high.
// ----------------------------------------------------------------------------
module front_middle_back_queue #(
	parameter int CAPACITY = fmbq_pkg::CAPACITY
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  fmbq_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output fmbq_pkg::rsp_t rsp
);

	// ring depth, a power of two, covers the larger half, ceil(CAPACITY/2), plus at least one spare slot
	localparam int ADDR_BITS = $clog2((CAPACITY + 1) / 2 + 1);

	// front ring half port signals
	logic                            f_we, f_re;
	logic [ADDR_BITS-1:0]            f_waddr, f_raddr;
	logic [fmbq_pkg::VALUE_BITS-1:0] f_wdata, f_rdata;

	// back ring half port signals
	logic                            b_we, b_re;
	logic [ADDR_BITS-1:0]            b_waddr, b_raddr;
	logic [fmbq_pkg::VALUE_BITS-1:0] b_wdata, b_rdata;

	// plan each request, track heads and counts, drive both rings
	fmbq_ctrl #(
		.CAPACITY  (CAPACITY),
		.ADDR_BITS (ADDR_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.f_we      (f_we),
		.f_waddr   (f_waddr),
		.f_wdata   (f_wdata),
		.f_re      (f_re),
		.f_raddr   (f_raddr),
		.f_rdata   (f_rdata),
		.b_we      (b_we),
		.b_waddr   (b_waddr),
		.b_wdata   (b_wdata),
		.b_re      (b_re),
		.b_raddr   (b_raddr),
		.b_rdata   (b_rdata)
	);

	// hold the first floor(n/2) entries
	fmbq_ring #(
		.ADDR_BITS (ADDR_BITS)
	) u_front_ring (
		.clk   (clk),
		.we    (f_we),
		.waddr (f_waddr),
		.wdata (f_wdata),
		.re    (f_re),
		.raddr (f_raddr),
		.rdata (f_rdata)
	);

	// hold the remaining ceil(n/2) entries
	fmbq_ring #(
		.ADDR_BITS (ADDR_BITS)
	) u_back_ring (
		.clk   (clk),
		.we    (b_we),
		.waddr (b_waddr),
		.wdata (b_wdata),
		.re    (b_re),
		.raddr (b_raddr),
		.rdata (b_rdata)
	);

endmodule

[design/fmbq_ring.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ring half storage
// Single-port-write, single-port-read synchronous memory with registered
// read data; one instance per ring half.
// ----------------------------------------------------------------------------
module fmbq_ring #(
	parameter int ADDR_BITS = fmbq_pkg::RING_ADDR_BITS
) (
	input  logic                            clk,
	input  logic                            we,
	input  logic [ADDR_BITS-1:0]            waddr,
	input  logic [fmbq_pkg::VALUE_BITS-1:0] wdata,
	input  logic                            re,
	input  logic [ADDR_BITS-1:0]            raddr,
	output logic [fmbq_pkg::VALUE_BITS-1:0] rdata
);

	localparam int DEPTH = 2 ** ADDR_BITS;

	logic [fmbq_pkg::VALUE_BITS-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[design/fmbq_ctrl.sv]
`timescale 1ns / 1ps
`include "front_middle_back_queue_macros.svh"
// ----------------------------------------------------------------------------
// Queue controller
// Keeps the head and count of each ring half, plans each request's memory
// accesses, moves one entry between halves to rebalance, and holds the
// response register.
// ----------------------------------------------------------------------------
module fmbq_ctrl #(
	parameter int CAPACITY  = fmbq_pkg::CAPACITY,
	parameter int ADDR_BITS = fmbq_pkg::RING_ADDR_BITS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            req_valid,
	output logic                            req_stall,
	input  fmbq_pkg::req_t                  req,
	output logic                            rsp_valid,
	input  logic                            rsp_stall,
	output fmbq_pkg::rsp_t                  rsp,
	output logic                            f_we,
	output logic [ADDR_BITS-1:0]            f_waddr,
	output logic [fmbq_pkg::VALUE_BITS-1:0] f_wdata,
	output logic                            f_re,
	output logic [ADDR_BITS-1:0]            f_raddr,
	input  logic [fmbq_pkg::VALUE_BITS-1:0] f_rdata,
	output logic                            b_we,
	output logic [ADDR_BITS-1:0]            b_waddr,
	output logic [fmbq_pkg::VALUE_BITS-1:0] b_wdata,
	output logic                            b_re,
	output logic [ADDR_BITS-1:0]            b_raddr,
	input  logic [fmbq_pkg::VALUE_BITS-1:0] b_rdata
);

	localparam int CW     = $clog2(CAPACITY + 1);
	localparam int RSP_CW = fmbq_pkg::COUNT_BITS;

	typedef logic [ADDR_BITS-1:0] addr_t;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RMW  = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	state_t        state_q;
	logic          acc;
	logic          in_rmw;

	logic [CW-1:0] f_cnt_q, b_cnt_q, f_cnt_n, b_cnt_n, total;
	addr_t         f_head_q, b_head_q, f_head_n, b_head_n;
	addr_t         f_cnt_a, b_cnt_a;
	addr_t         f_front_m1, f_back, f_last, b_front_m1, b_back, b_last;
	logic          f_eq_b, b_gt_f, full, empty;

	// plan of the current request
	logic          fw, bw, fr, br, mv_f, mv_b, pop_f, pop_b, p_empty, p_ovf;
	addr_t         fw_addr, bw_addr, fr_addr, br_addr, mv_addr;

	// read-modify-write stage
	logic          mv_to_f_s1, mv_to_b_s1, pop_f_s1, pop_b_s1;
	addr_t         mv_addr_s1;
	fmbq_pkg::rsp_t rsp_q;

	assign in_rmw    = (state_q == ST_RMW);
	assign rsp_valid = (state_q == ST_DONE);
	assign req_stall = !((state_q == ST_IDLE) || ((state_q == ST_DONE) && !rsp_stall));
	assign acc       = req_valid && !req_stall;
	assign rsp       = rsp_q;

	assign total      = f_cnt_q + b_cnt_q;
	assign f_cnt_a    = f_cnt_q[ADDR_BITS-1:0];
	assign b_cnt_a    = b_cnt_q[ADDR_BITS-1:0];
	assign f_front_m1 = f_head_q - addr_t'(1);
	assign f_back     = f_head_q + f_cnt_a;
	assign f_last     = f_head_q + f_cnt_a - addr_t'(1);
	assign b_front_m1 = b_head_q - addr_t'(1);
	assign b_back     = b_head_q + b_cnt_a;
	assign b_last     = b_head_q + b_cnt_a - addr_t'(1);
	assign f_eq_b     = (f_cnt_q == b_cnt_q);
	assign b_gt_f     = (b_cnt_q == f_cnt_q + CW'(1));
	assign full       = (total >= CW'(CAPACITY));
	assign empty      = (total == '0);

	always_comb begin
		fw       = 1'b0;
		bw       = 1'b0;
		fr       = 1'b0;
		br       = 1'b0;
		mv_f     = 1'b0;
		mv_b     = 1'b0;
		pop_f    = 1'b0;
		pop_b    = 1'b0;
		p_empty  = 1'b0;
		p_ovf    = 1'b0;
		fw_addr  = f_front_m1;
		bw_addr  = b_front_m1;
		fr_addr  = f_last;
		br_addr  = b_head_q;
		mv_addr  = f_back;
		f_cnt_n  = f_cnt_q;
		b_cnt_n  = b_cnt_q;
		f_head_n = f_head_q;
		b_head_n = b_head_q;
		case (req.opcode)
			fmbq_pkg::OP_PUSH_FRONT: begin
				if (full) begin
					p_ovf = 1'b1;
				end else if (f_eq_b && (f_cnt_q == '0)) begin
					// both halves empty: value lands in the back half
					bw       = 1'b1;
					b_head_n = b_front_m1;
					b_cnt_n  = b_cnt_q + CW'(1);
				end else if (f_eq_b) begin
					// push, then move the old front-half tail to the back half
					fw       = 1'b1;
					f_head_n = f_front_m1;
					fr       = 1'b1;
					fr_addr  = f_last;
					mv_b     = 1'b1;
					mv_addr  = b_front_m1;
					b_head_n = b_front_m1;
					b_cnt_n  = b_cnt_q + CW'(1);
				end else begin
					fw       = 1'b1;
					f_head_n = f_front_m1;
					f_cnt_n  = f_cnt_q + CW'(1);
				end
			end
			fmbq_pkg::OP_PUSH_MIDDLE: begin
				if (full) begin
					p_ovf = 1'b1;
				end else if (f_eq_b) begin
					bw       = 1'b1;
					b_head_n = b_front_m1;
					b_cnt_n  = b_cnt_q + CW'(1);
				end else begin
					fw      = 1'b1;
					fw_addr = f_back;
					f_cnt_n = f_cnt_q + CW'(1);
				end
			end
			fmbq_pkg::OP_PUSH_BACK: begin
				if (full) begin
					p_ovf = 1'b1;
				end else begin
					bw      = 1'b1;
					bw_addr = b_back;
					if (b_gt_f) begin
						// move the back-half head into the front-half tail
						br       = 1'b1;
						br_addr  = b_head_q;
						b_head_n = b_head_q + addr_t'(1);
						mv_f     = 1'b1;
						mv_addr  = f_back;
						f_cnt_n  = f_cnt_q + CW'(1);
					end else begin
						b_cnt_n = b_cnt_q + CW'(1);
					end
				end
			end
			fmbq_pkg::OP_POP_FRONT: begin
				if (empty) begin
					p_empty = 1'b1;
				end else if (f_cnt_q == '0) begin
					br       = 1'b1;
					pop_b    = 1'b1;
					b_head_n = b_head_q + addr_t'(1);
					b_cnt_n  = b_cnt_q - CW'(1);
				end else begin
					fr       = 1'b1;
					fr_addr  = f_head_q;
					pop_f    = 1'b1;
					f_head_n = f_head_q + addr_t'(1);
					if (b_gt_f) begin
						br       = 1'b1;
						b_head_n = b_head_q + addr_t'(1);
						b_cnt_n  = b_cnt_q - CW'(1);
						mv_f     = 1'b1;
						mv_addr  = f_back;
					end else begin
						f_cnt_n = f_cnt_q - CW'(1);
					end
				end
			end
			fmbq_pkg::OP_POP_MIDDLE: begin
				if (empty) begin
					p_empty = 1'b1;
				end else if (f_eq_b) begin
					fr      = 1'b1;
					fr_addr = f_last;
					pop_f   = 1'b1;
					f_cnt_n = f_cnt_q - CW'(1);
				end else begin
					br       = 1'b1;
					pop_b    = 1'b1;
					b_head_n = b_head_q + addr_t'(1);
					b_cnt_n  = b_cnt_q - CW'(1);
				end
			end
			fmbq_pkg::OP_POP_BACK: begin
				if (empty) begin
					p_empty = 1'b1;
				end else begin
					br      = 1'b1;
					br_addr = b_last;
					pop_b   = 1'b1;
					if (f_eq_b) begin
						// refill the back half from the front-half tail
						fr       = 1'b1;
						fr_addr  = f_last;
						f_cnt_n  = f_cnt_q - CW'(1);
						mv_b     = 1'b1;
						mv_addr  = b_front_m1;
						b_head_n = b_front_m1;
					end else begin
						b_cnt_n = b_cnt_q - CW'(1);
					end
				end
			end
			default: begin
			end
		endcase
	end

	// memory ports: request writes in the accept cycle, moves in the cycle after
	assign f_we    = (acc && fw) || (in_rmw && mv_to_f_s1);
	assign f_waddr = in_rmw ? mv_addr_s1 : fw_addr;
	assign f_wdata = in_rmw ? b_rdata : req.push_value;
	assign f_re    = acc && fr;
	assign f_raddr = fr_addr;
	assign b_we    = (acc && bw) || (in_rmw && mv_to_b_s1);
	assign b_waddr = in_rmw ? mv_addr_s1 : bw_addr;
	assign b_wdata = in_rmw ? f_rdata : req.push_value;
	assign b_re    = acc && br;
	assign b_raddr = br_addr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			f_cnt_q    <= '0;
			b_cnt_q    <= '0;
			f_head_q   <= '0;
			b_head_q   <= '0;
			mv_to_f_s1 <= 1'b0;
			mv_to_b_s1 <= 1'b0;
			pop_f_s1   <= 1'b0;
			pop_b_s1   <= 1'b0;
		end else begin
			if (acc) begin
				f_cnt_q    <= f_cnt_n;
				b_cnt_q    <= b_cnt_n;
				f_head_q   <= f_head_n;
				b_head_q   <= b_head_n;
				mv_to_f_s1 <= mv_f;
				mv_to_b_s1 <= mv_b;
				pop_f_s1   <= pop_f;
				pop_b_s1   <= pop_b;
			end
			case (state_q)
				ST_IDLE: begin
					if (acc) begin
						state_q <= ST_RMW;
					end
				end
				ST_RMW: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (acc) begin
						state_q <= ST_RMW;
					end else if (!rsp_stall) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			mv_addr_s1         <= mv_addr;
			rsp_q.popped_value <= '0;
			rsp_q.was_empty    <= p_empty;
			rsp_q.overflow     <= p_ovf;
			rsp_q.entry_count  <= RSP_CW'(f_cnt_n + b_cnt_n);
		end else if (in_rmw) begin
			if (pop_f_s1) begin
				rsp_q.popped_value <= f_rdata;
			end else if (pop_b_s1) begin
				rsp_q.popped_value <= b_rdata;
			end
		end
	end

	`FMBQ_ASSERT(a_half_balance, clk, arst_n, f_eq_b || b_gt_f, "ring halves out of balance")
	`FMBQ_ASSERT(a_count_bound, clk, arst_n, total <= CW'(CAPACITY), "entry count above capacity")
	`FMBQ_ASSERT_IMPL(a_f_rw_clash, clk, arst_n, f_we && f_re, f_waddr != f_raddr, "front ring clash")
	`FMBQ_ASSERT_IMPL(a_b_rw_clash, clk, arst_n, b_we && b_re, b_waddr != b_raddr, "back ring clash")
	`FMBQ_ASSERT_IMPL(a_rsp_latency, clk, arst_n, acc, ##2 rsp_valid, "response not on time")

endmodule

[tb/tb_front_middle_back_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Front/middle/back queue testbench
// Drives push and pop requests at the front, middle and back of the queue,
// keeps a plain ordered copy of the queue contents to predict every response,
// and compares each response field by field in arrival order. Runs directed
// corner cases, a fill past capacity, and random traffic under three idle
// patterns, plus a long response hold-off and a full drain pause.
// ----------------------------------------------------------------------------
module tb_front_middle_back_queue;

	localparam int CLK_PERIOD   = 10;
	localparam int RESET_CYCLES = 7;
	localparam int HOLD_CYCLES  = 300;
	// longest quiet stretch is the hold-off; leave a wide margin above it
	localparam int QUIET_LIMIT  = 2000;
	// let the block settle after the last response before the verdict
	localparam int SETTLE_CYCLES = 12;

	localparam int CAPACITY    = fmbq_pkg::CAPACITY;
	localparam int VALUE_BITS  = fmbq_pkg::VALUE_BITS;
	localparam int OPCODE_BITS = fmbq_pkg::OPCODE_BITS;
	localparam int COUNT_BITS  = fmbq_pkg::COUNT_BITS;

	// opcodes the block treats as no-ops
	localparam logic [OPCODE_BITS-1:0] OP_RESERVED_LO = 3'd6;
	localparam logic [OPCODE_BITS-1:0] OP_RESERVED_HI = 3'd7;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	fmbq_pkg::req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	fmbq_pkg::rsp_t rsp;

	// ordered copy of what the queue holds, index 0 at the front
	logic [VALUE_BITS-1:0] queue_contents[$];
	// responses predicted at request acceptance, oldest first
	fmbq_pkg::rsp_t pending_responses[$];

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_left = 0;
	int error_count = 0;
	int quiet_cycles = 0;

	front_middle_back_queue dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Apply one request to the queue copy and return the response it yields.
	// Middle push lands at floor(n/2); middle pop takes floor((n-1)/2).
	function automatic fmbq_pkg::rsp_t next_queue_response(input fmbq_pkg::req_t item);
		fmbq_pkg::rsp_t result;
		int unsigned n;
		int unsigned idx;
		result = '0;
		n = queue_contents.size();
		case (item.opcode)
			fmbq_pkg::OP_PUSH_FRONT, fmbq_pkg::OP_PUSH_MIDDLE, fmbq_pkg::OP_PUSH_BACK: begin
				if (n >= CAPACITY) begin
					// full: drop the value and flag it
					result.overflow = 1'b1;
				end else if (item.opcode == fmbq_pkg::OP_PUSH_FRONT) begin
					queue_contents.insert(0, item.push_value);
				end else if (item.opcode == fmbq_pkg::OP_PUSH_MIDDLE) begin
					queue_contents.insert(n / 2, item.push_value);
				end else begin
					queue_contents.insert(n, item.push_value);
				end
			end
			fmbq_pkg::OP_POP_FRONT, fmbq_pkg::OP_POP_MIDDLE, fmbq_pkg::OP_POP_BACK: begin
				if (n == 0) begin
					// empty: report it, value stays zero
					result.was_empty = 1'b1;
				end else if (item.opcode == fmbq_pkg::OP_POP_FRONT) begin
					result.popped_value = queue_contents[0];
					queue_contents.delete(0);
				end else if (item.opcode == fmbq_pkg::OP_POP_MIDDLE) begin
					idx = (n - 1) / 2;
					result.popped_value = queue_contents[idx];
					queue_contents.delete(idx);
				end else begin
					result.popped_value = queue_contents[n - 1];
					queue_contents.delete(n - 1);
				end
			end
			default: begin
				// reserved opcode: no state change, count only
			end
		endcase
		result.entry_count = COUNT_BITS'(queue_contents.size());
		return result;
	endfunction

	// Favor the value extremes now and then so both ends of the range show up.
	function automatic logic [VALUE_BITS-1:0] random_value();
		logic [31:0] raw;
		raw = $urandom;
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			default: return raw[VALUE_BITS-1:0];
		endcase
	endfunction

	function automatic logic [OPCODE_BITS-1:0] random_push_op();
		case ($urandom_range(2))
			0: return fmbq_pkg::OP_PUSH_FRONT;
			1: return fmbq_pkg::OP_PUSH_MIDDLE;
			default: return fmbq_pkg::OP_PUSH_BACK;
		endcase
	endfunction

	function automatic logic [OPCODE_BITS-1:0] random_pop_op();
		case ($urandom_range(2))
			0: return fmbq_pkg::OP_POP_FRONT;
			1: return fmbq_pkg::OP_POP_MIDDLE;
			default: return fmbq_pkg::OP_POP_BACK;
		endcase
	endfunction

	// Mostly pushes or pops by the given bias, with a sprinkle of reserved codes.
	function automatic logic [OPCODE_BITS-1:0] random_op(input int push_pct);
		if ($urandom_range(99) < 4)
			return $urandom_range(1) ? OP_RESERVED_HI : OP_RESERVED_LO;
		if ($urandom_range(99) < push_pct)
			return random_push_op();
		return random_pop_op();
	endfunction

	// Offer one request transaction and return at the edge that accepts it.
	// Enter any time; drive at the falling edge, sample at the rising edge.
	task automatic send_request(input logic [OPCODE_BITS-1:0] opcode,
			input logic [VALUE_BITS-1:0] value);
		fmbq_pkg::req_t item;
		fmbq_pkg::rsp_t predicted;
		item.opcode = opcode;
		item.push_value = value;
		@(negedge clk);
		// idle the request line for a random number of cycles
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req <= item;
		// hold the payload until the block takes it
		do
			@(posedge clk);
		while (req_stall);
		predicted = next_queue_response(item);
		pending_responses.insert(pending_responses.size(), predicted);
	endtask

	// Drop valid and pause until every predicted response has arrived.
	task automatic wait_for_responses();
		@(negedge clk);
		req_valid <= 1'b0;
		while (pending_responses.size() != 0)
			@(negedge clk);
	endtask

	// Empty pops on each side, reserved codes, value extremes, every push and
	// pop kind, a middle push on an empty queue and a middle pop on a queue of one.
	task automatic test_directed();
		send_request(fmbq_pkg::OP_POP_FRONT, random_value());
		send_request(fmbq_pkg::OP_POP_MIDDLE, random_value());
		send_request(fmbq_pkg::OP_POP_BACK, random_value());
		send_request(OP_RESERVED_LO, '1);
		send_request(OP_RESERVED_HI, '0);
		send_request(fmbq_pkg::OP_PUSH_BACK, '0);
		send_request(fmbq_pkg::OP_PUSH_FRONT, '1);
		send_request(fmbq_pkg::OP_PUSH_MIDDLE, 31'h2AAA_AAAA);
		send_request(fmbq_pkg::OP_PUSH_MIDDLE, 31'h5555_5555);
		send_request(fmbq_pkg::OP_PUSH_BACK, 31'h0000_0001);
		send_request(fmbq_pkg::OP_PUSH_FRONT, 31'h4000_0000);
		send_request(OP_RESERVED_HI, random_value());
		send_request(fmbq_pkg::OP_POP_MIDDLE, random_value());
		send_request(fmbq_pkg::OP_POP_FRONT, random_value());
		send_request(fmbq_pkg::OP_POP_BACK, random_value());
		send_request(fmbq_pkg::OP_POP_MIDDLE, random_value());
		send_request(fmbq_pkg::OP_POP_MIDDLE, random_value());
		send_request(fmbq_pkg::OP_POP_MIDDLE, random_value());
		send_request(fmbq_pkg::OP_POP_MIDDLE, random_value());
		send_request(fmbq_pkg::OP_PUSH_MIDDLE, 31'h1234_5678);
		send_request(fmbq_pkg::OP_POP_MIDDLE, random_value());
	endtask

	// Fill to capacity with random push kinds, then overflow each kind and
	// churn around the full mark.
	task automatic test_fill_to_capacity();
		while (queue_contents.size() < CAPACITY)
			send_request(random_push_op(), random_value());
		send_request(fmbq_pkg::OP_PUSH_FRONT, random_value());
		send_request(fmbq_pkg::OP_PUSH_MIDDLE, random_value());
		send_request(fmbq_pkg::OP_PUSH_BACK, random_value());
		send_request(OP_RESERVED_LO, random_value());
		repeat (30)
			send_request(random_op(queue_contents.size() >= CAPACITY ? 30 : 70),
				random_value());
	endtask

	// Random traffic in segments that alternate between growing and shrinking.
	task automatic test_random_mix(input int items);
		int push_pct;
		push_pct = 30;
		for (int i = 0; i < items; i++) begin
			if (i % 40 == 0)
				push_pct = (push_pct == 30) ? 70 : 30;
			send_request(random_op(push_pct), random_value());
		end
	endtask

	// Hold the response channel off for a long stretch while requests keep
	// coming, so the block backs up and stalls its input.
	task automatic test_response_holdoff();
		hold_left = HOLD_CYCLES;
		repeat (24)
			send_request(random_op(50), random_value());
	endtask

	// Pause the sender until the block has answered everything, then resume.
	task automatic test_drain_pause();
		repeat (12)
			send_request(random_op(60), random_value());
		wait_for_responses();
		repeat (12)
			send_request(random_op(60), random_value());
	endtask

	// Receiver: stall at random, or for a whole hold-off when one is asked.
	always @(negedge clk) begin
		if (hold_left > 0) begin
			rsp_stall <= 1'b1;
			hold_left--;
		end else begin
			rsp_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// Compare each accepted response with the oldest prediction.
	always @(posedge clk) begin
		fmbq_pkg::rsp_t expected_rsp;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_responses.size() == 0) begin
				$error("response with no request waiting: popped_value %0d", rsp.popped_value);
				error_count++;
			end else begin
				expected_rsp = pending_responses[0];
				pending_responses.delete(0);
				if (rsp.popped_value !== expected_rsp.popped_value) begin
					$error("popped_value: expected %0d, got %0d",
						expected_rsp.popped_value, rsp.popped_value);
					error_count++;
				end
				if (rsp.was_empty !== expected_rsp.was_empty) begin
					$error("was_empty: expected %0d, got %0d",
						expected_rsp.was_empty, rsp.was_empty);
					error_count++;
				end
				if (rsp.overflow !== expected_rsp.overflow) begin
					$error("overflow: expected %0d, got %0d",
						expected_rsp.overflow, rsp.overflow);
					error_count++;
				end
				if (rsp.entry_count !== expected_rsp.entry_count) begin
					$error("entry_count: expected %0d, got %0d",
						expected_rsp.entry_count, rsp.entry_count);
					error_count++;
				end
			end
		end
	end

	// Watchdog: end the run when no transaction moves for too long.
	initial begin
		forever begin
			@(posedge clk);
			if (!arst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT)
				break;
		end
		$display("tb_front_middle_back_queue NOT OK");
		$finish;
	end

	initial begin
		// hold reset, then release it away from the rising edge
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// sender idles lightly, receiver heavily
		send_idle_pct = 31;
		recv_idle_pct = 54;
		test_directed();
		test_fill_to_capacity();
		test_random_mix(200);

		// swap the idle pattern
		send_idle_pct = 54;
		recv_idle_pct = 31;
		test_random_mix(180);
		test_response_holdoff();

		// run at full rate on both sides
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_drain_pause();
		test_random_mix(180);

		wait_for_responses();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("tb_front_middle_back_queue OK");
		else
			$display("tb_front_middle_back_queue NOT OK");
		$finish;
	end

endmodule

[sim.f]
+incdir+design
design/fmbq_pkg.sv
design/fmbq_ring.sv
design/fmbq_ctrl.sv
design/front_middle_back_queue.sv
tb/tb_front_middle_back_queue.sv
